### src/assert_macros.svh
// assertion macros used by the rtl of the rank tracker
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define PRT_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define PRT_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/prt_pkg.sv
// shared types and constants of the percentile rank tracker
// no dependencies
`timescale 1ns / 1ps

package prt_pkg;

	localparam int DEF_USER_SLOTS = 4096;
	localparam int DEF_PAGE_LIMIT = 1023;

	localparam int UID_FW  = 12;
	localparam int PAGE_FW = 10;
	localparam int CNT_FW  = 12;
	localparam int FRAC_W  = 17;
	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_CHEER = 1'b1;

	typedef struct packed {
		logic               command;
		logic [UID_FW-1:0]  user_id;
		logic [PAGE_FW-1:0] pages_read;
	} in_beat_t;

	typedef struct packed {
		logic              user_known;
		logic [CNT_FW-1:0] below_count;
		logic [CNT_FW-1:0] others_count;
		logic [FRAC_W-1:0] fraction;
	} out_beat_t;

endpackage

### src/prt_in_if.sv
// command channel of the rank tracker
// depends on prt_pkg
`timescale 1ns / 1ps

interface prt_in_if import prt_pkg::*; ;
	logic     valid;
	logic     ready;
	in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/prt_out_if.sv
// result channel of the rank tracker
// depends on prt_pkg
`timescale 1ns / 1ps

interface prt_out_if import prt_pkg::*; ;
	logic      valid;
	logic      ready;
	out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/percentile_rank_tracker_core.sv
// Percentile rank tracker: command channel in_ch (read or cheer), result channel out_ch.
// A read stores a user's page count and adjusts the per-level counters; it gives no
// result. A cheer gives one result: whether the user is known, how many other active
// users have fewer pages, how many others there are, and that ratio in Q1.16.
// Items are taken one at a time; in_ch.ready is high only when the sequencer is idle.
// For a read, one level counter is read, then written, per level between the old and
// the new count (single-port level memory). A cheer for a known user with other
// active users goes through the bit-serial divider. After reset a clearing pass over
// max(USER_SLOTS, PAGE_LIMIT+1) addresses (4096 by default) zeroes both memories; no
// command is taken meanwhile.
// The result sits in an output register until out_ch.ready; a new command can be
// taken while it waits, and a later cheer holds in its last state while the
// register is still full.
// Depends on prt_pkg, prt_in_if, prt_out_if, prt_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module percentile_rank_tracker_core import prt_pkg::*; #(
	parameter int USER_SLOTS = DEF_USER_SLOTS,
	parameter int PAGE_LIMIT = DEF_PAGE_LIMIT
) (
	input logic       clk,
	input logic       arst_n,
	prt_in_if.sink    in_ch,
	prt_out_if.source out_ch
);

	localparam int UID_W     = $clog2(USER_SLOTS);
	localparam int PG_W      = $clog2(PAGE_LIMIT + 1);
	localparam int CNT_W     = $clog2(USER_SLOTS + 1);
	localparam int LVL_DEPTH = PAGE_LIMIT + 1;
	localparam int CLR_N     = (USER_SLOTS > LVL_DEPTH) ? USER_SLOTS : LVL_DEPTH;
	localparam int CLR_W     = $clog2(CLR_N);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_U_RD, ST_U_CHK, ST_L_RD, ST_L_WR,
		ST_C_RD, ST_C_LV, ST_DIV, ST_DONE
	} state_t;

	state_t           state_q;
	logic [CLR_W-1:0] clr_q;
	logic             cmd_q;
	logic [UID_W-1:0] uid_q;
	logic [PG_W-1:0]  newp_q;
	logic [PG_W:0]    lv_q;
	logic [PG_W:0]    end_q;
	logic             up_q;
	logic [CNT_W-1:0] active_q;
	logic             known_q;
	logic [CNT_W-1:0] below_q;
	logic [CNT_W-1:0] others_q;
	logic [FRAC_W-1:0] frac_q;
	logic             out_valid_q;
	out_beat_t        out_q;

	// memories and their registered read data
	logic [PG_W-1:0]  user_mem [USER_SLOTS];
	logic [CNT_W-1:0] lvl_mem [LVL_DEPTH];
	logic [PG_W-1:0]  u_rd_q;
	logic [CNT_W-1:0] l_rd_q;

	logic             u_re, u_we, l_re, l_we;
	logic [UID_W-1:0] u_addr;
	logic [PG_W-1:0]  u_wdata;
	logic [PG_W-1:0]  l_addr;
	logic [CNT_W-1:0] l_wdata;

	logic                   in_fire;
	logic                   uid_ok;
	logic [UID_W+UID_FW-1:0] uid_wide;
	logic [PG_W+PAGE_FW-1:0] pg_wide;
	logic [PG_W-1:0]         pg_sat;
	logic [CNT_W-1:0]        below_raw;
	logic [CNT_W-1:0]        others_c;
	logic [CNT_W+CNT_FW-1:0] below_ext;
	logic [CNT_W+CNT_FW-1:0] others_ext;
	logic                    div_start;
	logic                    div_done;
	logic [FRAC_W-1:0]       div_quo;

	// input decode
	always_comb begin
		in_fire  = in_ch.valid && in_ch.ready;
		uid_ok   = 32'(in_ch.data.user_id) < USER_SLOTS;
		uid_wide = {{UID_W{1'b0}}, in_ch.data.user_id};
		pg_wide  = {{PG_W{1'b0}}, in_ch.data.pages_read};
		pg_sat   = (pg_wide > (PG_W+PAGE_FW)'(PAGE_LIMIT)) ? PG_W'(PAGE_LIMIT)
		                                                   : pg_wide[PG_W-1:0];
	end

	// rank arithmetic for a cheer
	always_comb begin
		others_c   = active_q - 1'b1;
		below_raw  = active_q - l_rd_q;
		below_ext  = {{CNT_FW{1'b0}}, below_q};
		others_ext = {{CNT_FW{1'b0}}, others_q};
	end

	// memory port control
	always_comb begin
		u_re    = 1'b0;
		u_we    = 1'b0;
		u_addr  = uid_q;
		u_wdata = newp_q;
		l_re    = 1'b0;
		l_we    = 1'b0;
		l_addr  = lv_q[PG_W-1:0];
		l_wdata = up_q ? l_rd_q + 1'b1 : l_rd_q - 1'b1;
		case (state_q)
			ST_CLEAR: begin
				u_we    = 1'b1;
				u_addr  = clr_q[UID_W-1:0];
				u_wdata = '0;
				l_we    = {1'b0, clr_q} < (CLR_W+1)'(LVL_DEPTH);
				l_addr  = clr_q[PG_W-1:0];
				l_wdata = '0;
			end
			ST_U_RD:  u_re = 1'b1;
			ST_U_CHK: u_we = cmd_q == CMD_READ;
			ST_L_RD:  l_re = 1'b1;
			ST_L_WR:  l_we = 1'b1;
			ST_C_RD:  l_re = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (u_we) begin
			user_mem[u_addr] <= u_wdata;
		end
		if (u_re) begin
			u_rd_q <= user_mem[u_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			lvl_mem[l_addr] <= l_wdata;
		end
		if (l_re) begin
			l_rd_q <= lvl_mem[l_addr];
		end
	end

	assign div_start = state_q == ST_C_LV;

	prt_div #(.CNT_W(CNT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ((below_raw > others_c) ? others_c : below_raw),
		.den    (others_c),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			active_q    <= '0;
			out_valid_q <= 1'b0;
			cmd_q       <= CMD_READ;
			uid_q       <= '0;
			newp_q      <= '0;
			lv_q        <= '0;
			end_q       <= '0;
			up_q        <= 1'b0;
			known_q     <= 1'b0;
			below_q     <= '0;
			others_q    <= '0;
			frac_q      <= '0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ch.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						cmd_q    <= in_ch.data.command;
						uid_q    <= uid_wide[UID_W-1:0];
						newp_q   <= pg_sat;
						known_q  <= 1'b0;
						below_q  <= '0;
						others_q <= '0;
						frac_q   <= '0;
						if (in_ch.data.command == CMD_READ) begin
							if (uid_ok && in_ch.data.pages_read != '0) begin
								state_q <= ST_U_RD;
							end
						end else if (uid_ok) begin
							state_q <= ST_U_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_U_RD: state_q <= ST_U_CHK;
				ST_U_CHK: begin
					if (cmd_q == CMD_READ) begin
						if (u_rd_q == '0) begin
							active_q <= active_q + 1'b1;
						end
						up_q <= newp_q > u_rd_q;
						if (newp_q > u_rd_q) begin
							lv_q  <= {1'b0, u_rd_q} + 1'b1;
							end_q <= {1'b0, newp_q};
						end else begin
							lv_q  <= {1'b0, newp_q} + 1'b1;
							end_q <= {1'b0, u_rd_q};
						end
						state_q <= (newp_q == u_rd_q) ? ST_IDLE : ST_L_RD;
					end else if (u_rd_q == '0) begin
						state_q <= ST_DONE;
					end else if (active_q <= CNT_W'(1)) begin
						known_q <= 1'b1;
						frac_q  <= FRAC_ONE;
						state_q <= ST_DONE;
					end else begin
						known_q <= 1'b1;
						lv_q    <= {1'b0, u_rd_q};
						state_q <= ST_C_RD;
					end
				end
				ST_L_RD: state_q <= ST_L_WR;
				ST_L_WR: begin
					if (lv_q == end_q) begin
						state_q <= ST_IDLE;
					end else begin
						lv_q    <= lv_q + 1'b1;
						state_q <= ST_L_RD;
					end
				end
				ST_C_RD: state_q <= ST_C_LV;
				ST_C_LV: begin
					below_q  <= (below_raw > others_c) ? others_c : below_raw;
					others_q <= others_c;
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q        <= 1'b1;
						out_q.user_known   <= known_q;
						out_q.below_count  <= below_ext[CNT_FW-1:0];
						out_q.others_count <= others_ext[CNT_FW-1:0];
						out_q.fraction     <= (others_q != '0) ? div_quo : frac_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready  = state_q == ST_IDLE;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// checks on the sequencer
	`PRT_ASSERT(a_active_bound, clk, arst_n, active_q <= CNT_W'(USER_SLOTS), "active count over slots")
	`PRT_ASSERT(a_div_to_done, clk, arst_n, (state_q == ST_DIV && div_done) |=> state_q == ST_DONE, "divider finish lost")
	`PRT_ASSERT(a_start_known, clk, arst_n, div_start |-> known_q && active_q > CNT_W'(1), "divide without two active users")
	`PRT_ASSERT_ALWAYS(a_reset_clear, clk, !arst_n |-> !out_ch.valid && !in_ch.ready, "channels live in reset")

endmodule

### src/prt_div.sv
// restoring divider, one quotient bit per cycle, for the Q1.16 rank fraction
// depends on prt_pkg; num must not exceed den
`timescale 1ns / 1ps

module prt_div import prt_pkg::*; #(
	parameter int CNT_W = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CNT_W-1:0]  num,
	input  logic [CNT_W-1:0]  den,
	output logic              done,
	output logic [FRAC_W-1:0] quo
);

	localparam int STEP_W = $clog2(FRAC_W + 1);

	logic [CNT_W:0]      rem_q;
	logic [CNT_W-1:0]    den_q;
	logic [FRAC_W-1:0]   quo_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W:0]      trial;
	logic                qbit;
	logic [CNT_W:0]      rem_next;

	// trial subtract of the divisor
	always_comb begin
		trial    = rem_q - {1'b0, den_q};
		qbit     = rem_q >= {1'b0, den_q};
		rem_next = qbit ? trial : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STEP_W'(FRAC_W);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (step_q != '0) begin
			rem_q <= {rem_next[CNT_W-1:0], 1'b0};
			quo_q <= {quo_q[FRAC_W-2:0], qbit};
		end
	end

	assign done = step_q == STEP_W'(1);
	assign quo  = quo_q;

endmodule
